/* rtl/core/jbse_pkg.sv */
// Shared widths, operation codes and stage records for the buffered JTAG shift engine.
package jbse_pkg;

  localparam int BUFFER_BYTES_DEF = 65;

  localparam int OP_W   = 3;
  localparam int IDX_W  = 7;
  localparam int DATA_W = 8;
  localparam int CNT_W  = 10;
  localparam int BIT_W  = 3;

  localparam logic [OP_W-1:0] OP_WRITE = 3'd0;
  localparam logic [OP_W-1:0] OP_START = 3'd1;
  localparam logic [OP_W-1:0] OP_TICK  = 3'd2;
  localparam logic [OP_W-1:0] OP_READ  = 3'd3;
  localparam logic [OP_W-1:0] OP_CLOCK = 3'd4;

  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [IDX_W-1:0]  byte_index;
    logic [DATA_W-1:0] write_byte;
    logic [CNT_W-1:0]  bit_count;
    logic              end_with_tms;
    logic              tdo_sample;
    logic              direct_tms;
    logic              direct_tdi;
  } item_t;

  typedef struct packed {
    logic              re;
    logic [IDX_W-1:0]  raddr;
    logic              we0;
    logic [IDX_W-1:0]  waddr0;
    logic [DATA_W-1:0] wdata0;
    logic              we1;
    logic [IDX_W-1:0]  waddr1;
  } mem_req_t;

  typedef struct packed {
    logic             tms_level;
    logic             mem_tdi;
    logic             direct_tdi;
    logic [BIT_W-1:0] bit_sel;
    logic             clock_pulse;
    logic             captured_tdo;
    logic             rd_en;
    logic             shifting;
    logic             shift_done;
    logic             count_error;
  } s1_info_t;

  typedef struct packed {
    logic              tms_level;
    logic              tdi_level;
    logic              clock_pulse;
    logic              captured_tdo;
    logic [DATA_W-1:0] read_byte;
    logic              shifting;
    logic              shift_done;
    logic              count_error;
  } res_t;

endpackage

/* rtl/core/jbse_if.sv */
// Valid/ready channel interfaces for the request and result beats.
interface jbse_in_if;
  logic                         valid;
  logic                         ready;
  logic [jbse_pkg::OP_W-1:0]    op;
  logic [jbse_pkg::IDX_W-1:0]   byte_index;
  logic [jbse_pkg::DATA_W-1:0]  write_byte;
  logic [jbse_pkg::CNT_W-1:0]   bit_count;
  logic                         end_with_tms;
  logic                         tdo_sample;
  logic                         direct_tms;
  logic                         direct_tdi;

  modport source (output valid, op, byte_index, write_byte, bit_count, end_with_tms,
                  tdo_sample, direct_tms, direct_tdi, input ready);
  modport sink (input valid, op, byte_index, write_byte, bit_count, end_with_tms,
                tdo_sample, direct_tms, direct_tdi, output ready);
endinterface

interface jbse_out_if;
  logic                         valid;
  logic                         ready;
  logic                         tms_level;
  logic                         tdi_level;
  logic                         clock_pulse;
  logic                         captured_tdo;
  logic [jbse_pkg::DATA_W-1:0]  read_byte;
  logic                         shifting;
  logic                         shift_done;
  logic                         count_error;

  modport source (output valid, tms_level, tdi_level, clock_pulse, captured_tdo, read_byte,
                  shifting, shift_done, count_error, input ready);
  modport sink (input valid, tms_level, tdi_level, clock_pulse, captured_tdo, read_byte,
                shifting, shift_done, count_error, output ready);
endinterface

/* rtl/core/jbse_ctrl.sv */
// Shift sequencer: counters, capture byte and buffer access requests for each beat.
module jbse_ctrl #(
  parameter int BUFFER_BYTES = jbse_pkg::BUFFER_BYTES_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               accept,
  input  jbse_pkg::item_t    item,
  output jbse_pkg::mem_req_t req,
  output jbse_pkg::s1_info_t info
);

  logic [jbse_pkg::CNT_W-1:0]  bits_left_r, bits_left_nxt;
  logic [jbse_pkg::CNT_W-1:0]  bit_pos_r, bit_pos_nxt;
  logic [jbse_pkg::DATA_W-1:0] cap_r, cap_nxt;
  logic                        tms_last_r, tms_last_nxt;

  logic [jbse_pkg::CNT_W-1:0]  bp_inc;
  logic [jbse_pkg::BIT_W-1:0]  bit_sel;
  logic [jbse_pkg::DATA_W-1:0] cap_new;
  logic                        last;
  logic                        tms_end;
  logic                        req_re, req_we0, req_we1;

  assign bp_inc  = bit_pos_r + 10'd1;
  assign bit_sel = bit_pos_r[jbse_pkg::BIT_W-1:0];
  assign cap_new = cap_r | (jbse_pkg::DATA_W'(item.tdo_sample) << bit_sel);
  assign last    = (bits_left_r == 10'd1);
  assign tms_end = last && tms_last_r;

  always_comb begin
    bits_left_nxt = bits_left_r;
    bit_pos_nxt   = bit_pos_r;
    cap_nxt       = cap_r;
    tms_last_nxt  = tms_last_r;
    req_re        = 1'b0;
    req_we0       = 1'b0;
    req_we1       = 1'b0;
    req.raddr     = item.byte_index;
    req.waddr0    = item.byte_index;
    req.wdata0    = item.write_byte;
    req.waddr1    = bp_inc[jbse_pkg::CNT_W-1:jbse_pkg::BIT_W];
    info          = '0;
    info.bit_sel  = bit_sel;
    unique case (item.op)
      jbse_pkg::OP_WRITE: begin
        req_we0 = 1'b1;
      end
      jbse_pkg::OP_START: begin
        if (int'(item.bit_count) > BUFFER_BYTES * 8) begin
          info.count_error = 1'b1;
        end else if (item.bit_count == '0) begin
          if (!item.end_with_tms) begin
            bits_left_nxt   = '0;
            bit_pos_nxt     = '0;
            cap_nxt         = '0;
            tms_last_nxt    = 1'b0;
            req_we0         = 1'b1;
            req.waddr0      = '0;
            req.wdata0      = '0;
            info.shift_done = 1'b1;
          end
        end else begin
          bits_left_nxt = item.bit_count;
          bit_pos_nxt   = '0;
          cap_nxt       = '0;
          tms_last_nxt  = item.end_with_tms;
        end
      end
      jbse_pkg::OP_TICK: begin
        if (bits_left_r != '0) begin
          req_re           = 1'b1;
          req.raddr        = bit_pos_r[jbse_pkg::CNT_W-1:jbse_pkg::BIT_W];
          req.waddr0       = bit_pos_r[jbse_pkg::CNT_W-1:jbse_pkg::BIT_W];
          req.wdata0       = cap_new;
          info.tms_level   = tms_end;
          info.mem_tdi     = 1'b1;
          info.clock_pulse = 1'b1;
          info.shift_done  = last;
          bits_left_nxt    = bits_left_r - 10'd1;
          bit_pos_nxt      = bp_inc;
          if (tms_end || last || (bit_sel == 3'd7)) begin
            req_we0 = 1'b1;
            cap_nxt = '0;
          end else begin
            cap_nxt = cap_new;
          end
          req_we1 = last && !tms_last_r && (bit_sel == 3'd7);
        end
      end
      jbse_pkg::OP_READ: begin
        req_re     = 1'b1;
        info.rd_en = int'(item.byte_index) < BUFFER_BYTES;
      end
      jbse_pkg::OP_CLOCK: begin
        info.tms_level    = item.direct_tms;
        info.direct_tdi   = item.direct_tdi;
        info.clock_pulse  = 1'b1;
        info.captured_tdo = item.tdo_sample;
      end
      default: begin
      end
    endcase
    info.shifting = (bits_left_nxt != '0);
    req.re  = accept && req_re;
    req.we0 = accept && req_we0;
    req.we1 = accept && req_we1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bits_left_r <= '0;
      bit_pos_r   <= '0;
      cap_r       <= '0;
      tms_last_r  <= 1'b0;
    end else if (accept) begin
      bits_left_r <= bits_left_nxt;
      bit_pos_r   <= bit_pos_nxt;
      cap_r       <= cap_nxt;
      tms_last_r  <= tms_last_nxt;
    end
  end

endmodule

/* rtl/core/jbse_buffer.sv */
// Byte buffer in even and odd banks with registered read and a clearing sweep after reset.
module jbse_buffer #(
  parameter int BUFFER_BYTES = jbse_pkg::BUFFER_BYTES_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  jbse_pkg::mem_req_t          req,
  output logic [jbse_pkg::DATA_W-1:0] rd_byte,
  output logic                        busy
);

  localparam int BANK_D  = (BUFFER_BYTES + 1) / 2;
  localparam int BANK_AW = (BANK_D > 1) ? $clog2(BANK_D) : 1;

  logic [jbse_pkg::DATA_W-1:0] even_mem [BANK_D];
  logic [jbse_pkg::DATA_W-1:0] odd_mem  [BANK_D];

  logic                        clr_busy_r;
  logic [BANK_AW-1:0]          clr_addr_r;
  logic                        ok0, ok1;
  logic                        even_we, odd_we;
  logic [BANK_AW-1:0]          even_addr, odd_addr, rd_addr;
  logic [jbse_pkg::DATA_W-1:0] even_data, odd_data;
  logic [jbse_pkg::DATA_W-1:0] rd_even_r, rd_odd_r;
  logic                        odd_sel_r;

  assign ok0     = req.we0 && (int'(req.waddr0) < BUFFER_BYTES);
  assign ok1     = req.we1 && (int'(req.waddr1) < BUFFER_BYTES);
  assign rd_addr = BANK_AW'(req.raddr >> 1);

  always_comb begin
    even_we   = 1'b0;
    even_addr = clr_addr_r;
    even_data = '0;
    odd_we    = 1'b0;
    odd_addr  = clr_addr_r;
    odd_data  = '0;
    priority if (clr_busy_r) begin
      even_we = 1'b1;
      odd_we  = 1'b1;
    end else begin
      if (ok0 && !req.waddr0[0]) begin
        even_we   = 1'b1;
        even_addr = BANK_AW'(req.waddr0 >> 1);
        even_data = req.wdata0;
      end else if (ok1 && !req.waddr1[0]) begin
        even_we   = 1'b1;
        even_addr = BANK_AW'(req.waddr1 >> 1);
      end
      if (ok0 && req.waddr0[0]) begin
        odd_we   = 1'b1;
        odd_addr = BANK_AW'(req.waddr0 >> 1);
        odd_data = req.wdata0;
      end else if (ok1 && req.waddr1[0]) begin
        odd_we   = 1'b1;
        odd_addr = BANK_AW'(req.waddr1 >> 1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (even_we) begin
      even_mem[even_addr] <= even_data;
    end
    if (odd_we) begin
      odd_mem[odd_addr] <= odd_data;
    end
    if (req.re) begin
      rd_even_r <= even_mem[rd_addr];
      rd_odd_r  <= odd_mem[rd_addr];
      odd_sel_r <= req.raddr[0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r <= 1'b1;
      clr_addr_r <= '0;
    end else if (clr_busy_r) begin
      clr_addr_r <= clr_addr_r + 1'b1;
      if (clr_addr_r == BANK_AW'(BANK_D - 1)) begin
        clr_busy_r <= 1'b0;
      end
    end
  end

  assign rd_byte = odd_sel_r ? rd_odd_r : rd_even_r;
  assign busy    = clr_busy_r;

endmodule

/* rtl/core/jbse_out.sv */
// Result pipeline: stage after the buffer read and the output register.
module jbse_out (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        accept,
  input  jbse_pkg::s1_info_t          info_nxt,
  input  logic [jbse_pkg::DATA_W-1:0] rd_byte,
  input  logic                        out_ready,
  output logic                        can_accept,
  output logic                        out_valid,
  output jbse_pkg::res_t              res
);

  logic               s1_valid_r;
  jbse_pkg::s1_info_t s1_info_r;
  logic               out_valid_r;
  jbse_pkg::res_t     out_r, out_nxt;
  logic               s1_move;

  assign s1_move    = s1_valid_r && (!out_valid_r || out_ready);
  assign can_accept = !s1_valid_r || s1_move;

  always_comb begin
    out_nxt.tms_level    = s1_info_r.tms_level;
    out_nxt.tdi_level    = s1_info_r.mem_tdi ? rd_byte[s1_info_r.bit_sel]
                                             : s1_info_r.direct_tdi;
    out_nxt.clock_pulse  = s1_info_r.clock_pulse;
    out_nxt.captured_tdo = s1_info_r.captured_tdo;
    out_nxt.read_byte    = s1_info_r.rd_en ? rd_byte : '0;
    out_nxt.shifting     = s1_info_r.shifting;
    out_nxt.shift_done   = s1_info_r.shift_done;
    out_nxt.count_error  = s1_info_r.count_error;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= accept || (s1_valid_r && !s1_move);
      if (s1_move) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_info_r <= info_nxt;
    end
    if (s1_move) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign res       = out_r;

endmodule

/* rtl/core/jtag_buffered_shift_engine.sv */
// Top level of the buffered JTAG shift engine.
//
// in_ch carries one request beat: write byte, start shift, bit tick, read byte or
// single clock. out_ch returns exactly one result beat per request, in order.
// A request is taken when in_ch.valid and in_ch.ready are both high.
// Path: a request's result beat passes one stage for the registered buffer read
// and then one output register before it is on out_ch; a stall at out_ch can hold
// it in either of them.
// Throughput: one request per cycle when out_ch does not stall and the sweep is
// done; even and odd banks let a tick write the closing byte and the byte after it.
// Reset: the shift counters clear, then the buffer is swept to zero, two bytes
// a cycle, one address of each bank at a time, while in_ch.ready stays low.
// When the receiver stalls, the output register holds its beat, the read stage
// behind it fills, and in_ch.ready drops only once both are occupied.
module jtag_buffered_shift_engine #(
  parameter int BUFFER_BYTES = jbse_pkg::BUFFER_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  jbse_in_if.sink     in_ch,
  jbse_out_if.source  out_ch
);

  jbse_pkg::item_t             item;
  jbse_pkg::mem_req_t          req;
  jbse_pkg::s1_info_t          info;
  jbse_pkg::res_t              res;
  logic [jbse_pkg::DATA_W-1:0] rd_byte;
  logic                        clr_busy;
  logic                        can_accept;
  logic                        accept;

  assign item.op           = in_ch.op;
  assign item.byte_index   = in_ch.byte_index;
  assign item.write_byte   = in_ch.write_byte;
  assign item.bit_count    = in_ch.bit_count;
  assign item.end_with_tms = in_ch.end_with_tms;
  assign item.tdo_sample   = in_ch.tdo_sample;
  assign item.direct_tms   = in_ch.direct_tms;
  assign item.direct_tdi   = in_ch.direct_tdi;

  assign in_ch.ready = !clr_busy && can_accept;
  assign accept      = in_ch.valid && in_ch.ready;

  jbse_ctrl #(.BUFFER_BYTES(BUFFER_BYTES)) u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .accept (accept),
    .item   (item),
    .req    (req),
    .info   (info)
  );

  jbse_buffer #(.BUFFER_BYTES(BUFFER_BYTES)) u_buffer (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (req),
    .rd_byte (rd_byte),
    .busy    (clr_busy)
  );

  jbse_out u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .accept     (accept),
    .info_nxt   (info),
    .rd_byte    (rd_byte),
    .out_ready  (out_ch.ready),
    .can_accept (can_accept),
    .out_valid  (out_ch.valid),
    .res        (res)
  );

  assign out_ch.tms_level    = res.tms_level;
  assign out_ch.tdi_level    = res.tdi_level;
  assign out_ch.clock_pulse  = res.clock_pulse;
  assign out_ch.captured_tdo = res.captured_tdo;
  assign out_ch.read_byte    = res.read_byte;
  assign out_ch.shifting     = res.shifting;
  assign out_ch.shift_done   = res.shift_done;
  assign out_ch.count_error  = res.count_error;

endmodule

/* rtl/core/jbse_checker.sv */
// Port-level assertions for the shift engine and their binding to the top level.
module jbse_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_ready,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic                        tms_level,
  input logic                        tdi_level,
  input logic                        clock_pulse,
  input logic                        captured_tdo,
  input logic [jbse_pkg::DATA_W-1:0] read_byte,
  input logic                        shifting,
  input logic                        shift_done,
  input logic                        count_error
);

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable({tms_level, tdi_level, clock_pulse,
      captured_tdo, read_byte, shifting, shift_done, count_error}))
    else $error("result beat changed while stalled");

  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !in_ready && !out_valid)
    else $error("ready or result valid straight after reset");

  a_idle_pins: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !clock_pulse |-> !tms_level && !tdi_level && !captured_tdo)
    else $error("pin levels reported without a clock pulse");

  a_error_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && count_error |-> !clock_pulse && !shift_done && (read_byte == '0))
    else $error("rejected start reported other activity");

  a_read_no_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (read_byte != '0) |-> !clock_pulse && !shift_done)
    else $error("read data on a clocking beat");

endmodule

bind jtag_buffered_shift_engine jbse_checker u_jbse_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_ready     (in_ch.ready),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .tms_level    (out_ch.tms_level),
  .tdi_level    (out_ch.tdi_level),
  .clock_pulse  (out_ch.clock_pulse),
  .captured_tdo (out_ch.captured_tdo),
  .read_byte    (out_ch.read_byte),
  .shifting     (out_ch.shifting),
  .shift_done   (out_ch.shift_done),
  .count_error  (out_ch.count_error)
);
